// File: rtl/core/rms_lvl_pkg.sv
// Shared types and fixed constants for the RMS level smoother.
package rms_lvl_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SQ_W     = 31;  // largest square is 32768*32768 = 2^30
  localparam int QUO_W    = 28;  // sum / (8n) never exceeds 2^27
  localparam int LVL_W    = 14;  // floor root of a QUO_W-bit value
  localparam int TALLY_W  = 16;
  localparam int SMOOTH_W = 16;
  localparam int QDEPTH   = 4;   // finished-buffer queue entries
  localparam int QCNT_W   = 3;   // holds 0..QDEPTH plus in-flight lasts

  localparam logic [15:0] COEF_OLD = 16'd60948;  // 0.93 * 2^16
  localparam logic [15:0] COEF_NEW = 16'd4588;   // 0.07 * 2^16

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic                       last_sample;
  } in_item_t;

  typedef struct packed {
    logic [LVL_W-1:0]   block_level;
    logic [LVL_W-1:0]   smoothed_level;
    logic [TALLY_W-1:0] buffers_done;
    logic               overflowed;
  } out_item_t;

endpackage

// File: rtl/core/rms_lvl_if.sv
// Valid/ready channel interfaces for sample input and level results.
interface rms_lvl_in_if
  import rms_lvl_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rms_lvl_out_if
  import rms_lvl_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/block_rms_level_smoother_core.sv
// Top level of the block RMS level meter with exponential smoothing.
// Throughput: one sample per cycle while in_chan.ready is high; ready drops while the
//   finished-buffer queue is spoken for, as the bit-serial back end takes one buffer at a time.
// Path: a last sample passes the front pipe and the queue, then the back end divides, roots and smooths.
// Reset: synchronous, active low; clears sums, counts, smoothed level and tally.
module block_rms_level_smoother_core
  import rms_lvl_pkg::*;
#(
  parameter int MAX_BUFFER = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  rms_lvl_in_if.sink   in_chan,
  rms_lvl_out_if.source out_chan
);

  // count must hold MAX_BUFFER itself; each square is at most 2^30
  localparam int CNT_W = $clog2(MAX_BUFFER + 1);
  localparam int SUM_W = 30 + CNT_W;
  localparam int ENT_W = SUM_W + CNT_W + 1;

  logic              in_acc;
  logic              push, pop, q_valid;
  logic [ENT_W-1:0]  push_data, pop_data;
  logic [QCNT_W-1:0] q_count;
  logic [1:0]        lasts_in_flight;

  // Hold input back only when every queue slot is spoken for by a
  // finished buffer, queued or still moving through the front pipe.
  assign in_chan.ready = (q_count + QCNT_W'(lasts_in_flight)) < QCNT_W'(QDEPTH);
  assign in_acc        = in_chan.valid & in_chan.ready;

  // front: take each sample transaction, square it and add it up
  rms_lvl_front #(
    .MAX_BUFFER (MAX_BUFFER),
    .CNT_W      (CNT_W),
    .SUM_W      (SUM_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (in_acc),
    .sample          (in_chan.data.left_sample),
    .last            (in_chan.data.last_sample),
    .push            (push),
    .push_data       (push_data),
    .lasts_in_flight (lasts_in_flight)
  );

  // queue: decouple accumulation from the slow per-buffer math
  rms_lvl_fifo #(
    .W (ENT_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (q_valid),
    .count     (q_count)
  );

  // back: divide by 8n, floor root, smooth and present the result
  rms_lvl_back #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (pop_data),
    .q_pop     (pop),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (out_chan.data)
  );

endmodule

// File: rtl/core/rms_lvl_front.sv
// Front end: magnitude, square and accumulate one sample per cycle.
module rms_lvl_front
  import rms_lvl_pkg::*;
#(
  parameter int MAX_BUFFER = 1024,
  parameter int CNT_W      = 11,
  parameter int SUM_W      = 41
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       last,
  output logic                       push,
  output logic [SUM_W+CNT_W:0]       push_data,
  output logic [1:0]                 lasts_in_flight
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BUFFER);

  // buffer position, tracked at acceptance
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             counted;
  logic [CNT_W-1:0] n_after;
  logic             ovf_after;
  logic [SAMPLE_W-1:0] s_u, mag;

  // stage 1: magnitude
  logic                s1_v_r, s1_last_r, s1_ovf_r;
  logic [SAMPLE_W-1:0] s1_mag_r;
  logic [CNT_W-1:0]    s1_n_r;

  // stage 2: square
  logic                s2_v_r, s2_last_r, s2_ovf_r;
  logic [SQ_W-1:0]     s2_sq_r;
  logic [CNT_W-1:0]    s2_n_r;
  logic [2*SAMPLE_W-1:0] sq_full;

  // stage 3: accumulate
  logic [SUM_W-1:0] sum_r, sum_sel;

  assign counted   = (cnt_r < MAX_CNT);
  assign n_after   = counted ? cnt_r + CNT_W'(1) : cnt_r;
  assign ovf_after = ovf_r | ~counted;
  assign s_u       = sample;
  assign mag       = s_u[SAMPLE_W-1] ? (~s_u + SAMPLE_W'(1)) : s_u;

  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (accept) begin
      cnt_nxt = last ? '0 : n_after;
      ovf_nxt = last ? 1'b0 : ovf_after;
    end
  end

  assign sq_full = s1_mag_r * s1_mag_r;
  assign sum_sel = sum_r + SUM_W'(s2_sq_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      sum_r  <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
      if (s2_v_r) begin
        sum_r <= s2_last_r ? '0 : sum_sel;
      end
    end
  end

  // payload stages need no reset
  always_ff @(posedge clk) begin
    s1_mag_r  <= counted ? mag : '0;
    s1_last_r <= last;
    s1_n_r    <= n_after;
    s1_ovf_r  <= ovf_after;
    s2_sq_r   <= sq_full[SQ_W-1:0];
    s2_last_r <= s1_last_r;
    s2_n_r    <= s1_n_r;
    s2_ovf_r  <= s1_ovf_r;
  end

  assign push      = s2_v_r & s2_last_r;
  assign push_data = {s2_ovf_r, s2_n_r, sum_sel};
  assign lasts_in_flight = {1'b0, s1_v_r & s1_last_r} + {1'b0, s2_v_r & s2_last_r};

endmodule

// File: rtl/core/rms_lvl_fifo.sv
// Short queue of finished-buffer totals between front and back.
module rms_lvl_fifo
  import rms_lvl_pkg::*;
#(
  parameter int W = 53
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [W-1:0]      push_data,
  input  logic              pop,
  output logic [W-1:0]      pop_data,
  output logic              not_empty,
  output logic [QCNT_W-1:0] count
);

  localparam int PTR_W = $clog2(QDEPTH);

  logic [W-1:0]      mem_r [QDEPTH];
  logic [PTR_W-1:0]  wp_r, rp_r;
  logic [QCNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + PTR_W'(1);
      end
      if (pop) begin
        rp_r <= rp_r + PTR_W'(1);
      end
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  assign pop_data  = mem_r[rp_r];
  assign not_empty = (cnt_r != '0);
  assign count     = cnt_r;

endmodule

// File: rtl/core/rms_lvl_back.sv
// Back end: divide, floor root, smoothing and result register.
module rms_lvl_back
  import rms_lvl_pkg::*;
#(
  parameter int CNT_W = 11,
  parameter int SUM_W = 41
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  logic [SUM_W+CNT_W:0] q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);

  localparam int STEP_W = $clog2(SUM_W + 1);
  localparam int DVS_W  = CNT_W + 3;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_ROOT = 3'd2;
  localparam logic [2:0] ST_MULO = 3'd3;
  localparam logic [2:0] ST_MULN = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]          state_r;
  logic [STEP_W-1:0]   step_r;
  logic [SUM_W-1:0]    dvd_r;
  logic [DVS_W-1:0]    dvs_r, rem_r;
  logic [QUO_W-1:0]    quo_r;
  logic [LVL_W-1:0]    root_r;
  logic [LVL_W+2:0]    rrem_r;
  logic                ovf_r;
  logic [31:0]         prod_old_r, prod_new_r;
  logic [SMOOTH_W-1:0] smooth_r, smooth_nxt;
  logic [TALLY_W-1:0]  tally_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  logic [SUM_W-1:0] q_sum;
  logic [CNT_W-1:0] q_n;
  logic             q_ovf;
  logic [DVS_W:0]   rem_sh, rem_sub;
  logic             div_ge;
  logic [LVL_W+4:0] rsh, rsub;
  logic [LVL_W+1:0] trial;
  logic             root_ge;
  logic [32:0]      mix;
  logic             load_out;

  assign q_sum = q_data[SUM_W-1:0];
  assign q_n   = q_data[SUM_W+CNT_W-1:SUM_W];
  assign q_ovf = q_data[SUM_W+CNT_W];
  assign q_pop = (state_r == ST_IDLE) & q_valid;

  // one quotient bit per cycle
  assign rem_sh  = {rem_r, dvd_r[SUM_W-1]};
  assign div_ge  = (rem_sh >= {1'b0, dvs_r});
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  // one root bit per cycle
  assign rsh     = {rrem_r, quo_r[QUO_W-1:QUO_W-2]};
  assign trial   = {root_r, 2'b01};
  assign root_ge = (rsh >= (LVL_W+5)'(trial));
  assign rsub    = rsh - (LVL_W+5)'(trial);

  assign mix        = {1'b0, prod_old_r} + {1'b0, prod_new_r};
  assign smooth_nxt = mix[31:16];
  assign load_out   = (state_r == ST_DONE) & (~out_valid_r | out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      smooth_r    <= '0;
      tally_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            step_r  <= STEP_W'(SUM_W);
            state_r <= (q_n == '0) ? ST_MULO : ST_DIV;
          end
        end
        ST_DIV: begin
          step_r <= step_r - STEP_W'(1);
          if (step_r == STEP_W'(1)) begin
            step_r  <= STEP_W'(LVL_W);
            state_r <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          step_r <= step_r - STEP_W'(1);
          if (step_r == STEP_W'(1)) begin
            state_r <= ST_MULO;
          end
        end
        ST_MULO: state_r <= ST_MULN;
        ST_MULN: state_r <= ST_DONE;
        ST_DONE: begin
          if (load_out) begin
            smooth_r <= smooth_nxt;
            tally_r  <= tally_r + TALLY_W'(1);
            state_r  <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        dvd_r  <= q_sum;
        dvs_r  <= {q_n, 3'b000};
        rem_r  <= '0;
        quo_r  <= '0;
        root_r <= '0;
        rrem_r <= '0;
        ovf_r  <= q_ovf;
      end
      ST_DIV: begin
        rem_r <= div_ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        quo_r <= {quo_r[QUO_W-2:0], div_ge};
        dvd_r <= {dvd_r[SUM_W-2:0], 1'b0};
      end
      ST_ROOT: begin
        rrem_r <= root_ge ? rsub[LVL_W+2:0] : rsh[LVL_W+2:0];
        root_r <= {root_r[LVL_W-2:0], root_ge};
        quo_r  <= {quo_r[QUO_W-3:0], 2'b00};
      end
      ST_MULO: prod_old_r <= COEF_OLD * smooth_r;
      ST_MULN: prod_new_r <= COEF_NEW * {2'b00, root_r};
      default: ;
    endcase
    if (load_out) begin
      out_data_r.block_level    <= root_r;
      out_data_r.smoothed_level <= smooth_nxt[LVL_W-1:0];
      out_data_r.buffers_done   <= tally_r + TALLY_W'(1);
      out_data_r.overflowed     <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
